>>> design/hpps_pkg.sv
// Shared types, constants and tables for the polar scan binning block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package hpps_pkg;

    localparam int BIN_COUNT_DEF = 360;

    // Field widths
    localparam int POS_W   = 20;
    localparam int ANG_W   = 16;
    localparam int MM_W    = 22;
    localparam int BNUM_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int DELTA_W = POS_W + 1;

    // CORDIC datapath: deltas scaled by 2^20, angle at 2^24 per turn
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_W     = 44;
    localparam int Z_W          = 24;
    localparam int CORDIC_FRAC  = 20;

    // Range datapath
    localparam int SQ_W   = 2 * DELTA_W;      // dx*dx + dy*dy
    localparam int N_W    = 54;               // sq * 2500
    localparam int SQRT_STEPS = N_W / 2;
    localparam int SCALE_TERMS = 5;

    // Bin index datapath
    localparam int NUM_W  = 28;               // |rel - first| * (BIN_COUNT - 1)
    localparam int PROD_W = 30;
    localparam int SPAN_W = 16;

    localparam logic [MM_W-1:0]  MM_SAT     = 22'h3F_FFFF;
    localparam logic [MM_W-1:0]  RESET_FILL = 22'd10000;
    localparam logic [5:0]       MM_PER_PX  = 6'd50;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_HIT   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_POSE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXRNG  = 3'd5;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 24'd2097152;
            5'd1:  v = 24'd1238021;
            5'd2:  v = 24'd654136;
            5'd3:  v = 24'd332050;
            5'd4:  v = 24'd166669;
            5'd5:  v = 24'd83416;
            5'd6:  v = 24'd41718;
            5'd7:  v = 24'd20860;
            5'd8:  v = 24'd10430;
            5'd9:  v = 24'd5215;
            5'd10: v = 24'd2608;
            5'd11: v = 24'd1304;
            5'd12: v = 24'd652;
            5'd13: v = 24'd326;
            5'd14: v = 24'd163;
            5'd15: v = 24'd81;
            5'd16: v = 24'd41;
            5'd17: v = 24'd20;
            default: v = '0;
        endcase
        return v;
    endfunction

    // 2500 = 2^11 + 2^8 + 2^7 + 2^6 + 2^2
    function automatic logic [3:0] scale_shift(input logic [2:0] idx);
        logic [3:0] s;
        case (idx)
            3'd0:    s = 4'd11;
            3'd1:    s = 4'd8;
            3'd2:    s = 4'd7;
            3'd3:    s = 4'd6;
            3'd4:    s = 4'd2;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

>>> design/hpps_bin_mem.sv
// Bin range store: single-port synchronous RAM, registered read.
// Depends on hpps_pkg for the control struct.
`timescale 1ns / 1ps

module hpps_bin_mem import hpps_pkg::*; #(
    parameter int DEPTH = BIN_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = MM_W
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/hpps_cordic.sv
// Vectoring CORDIC, one iteration per cycle: bearing of (dx, dy).
// Depends on hpps_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module hpps_cordic import hpps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_dx,
    input  logic [DELTA_W-1:0] i_dy,
    output logic               o_valid,
    output logic [ANG_W-1:0]   o_bearing
);

    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic [Z_W-1:0]             r_z;
    logic [4:0]                 r_cnt;
    logic                       r_busy, r_valid, r_zero;

    logic signed [CORDIC_W-1:0] w_x0, w_y0, w_xr, w_yr, w_xs, w_ys;
    logic [Z_W-1:0]             w_zr, w_zround;

    always_comb begin
        w_x0 = {{(CORDIC_W-DELTA_W-CORDIC_FRAC){i_dx[DELTA_W-1]}}, i_dx, {CORDIC_FRAC{1'b0}}};
        w_y0 = {{(CORDIC_W-DELTA_W-CORDIC_FRAC){i_dy[DELTA_W-1]}}, i_dy, {CORDIC_FRAC{1'b0}}};
        w_xr = w_x0;
        w_yr = w_y0;
        w_zr = '0;
        // left half plane: quarter turn into the right half first
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                w_xr = w_y0;
                w_yr = -w_x0;
                w_zr = 24'h40_0000;
            end else begin
                w_xr = -w_y0;
                w_yr = w_x0;
                w_zr = 24'hC0_0000;
            end
        end
        w_xs = r_x >>> r_cnt;
        w_ys = r_y >>> r_cnt;
        w_zround = r_z + 24'd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_x     <= w_xr;
            r_y     <= w_yr;
            r_z     <= w_zr;
            r_zero  <= (i_dx == '0) && (i_dy == '0);
        end else if (r_busy) begin
            if (!r_y[CORDIC_W-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + atan_entry(r_cnt);
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - atan_entry(r_cnt);
            end
            if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_valid   = r_valid;
    assign o_bearing = r_zero ? '0 : w_zround[Z_W-1:Z_W-ANG_W];

    property p_valid_not_busy;
        @(posedge i_clk) disable iff (!i_rst_n) !(r_valid && r_busy);
    endproperty
    a_valid_not_busy: assert property (p_valid_not_busy) else $error("cordic valid while busy");

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_cnt < 5'(CORDIC_STEPS));
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("cordic step count overrun");

    property p_finish;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_valid) |-> $past(r_busy);
    endproperty
    a_finish: assert property (p_finish) else $error("cordic valid without a run");

endmodule

>>> design/hpps_range.sv
// Range unit: squared distance through one shared multiplier, times 2500 by
// shift-add, then a bit-per-cycle integer square root. Depends on hpps_pkg.
`timescale 1ns / 1ps

module hpps_range import hpps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_dx,
    input  logic [DELTA_W-1:0] i_dy,
    output logic               o_valid,
    output logic [MM_W-1:0]    o_range_mm
);

    typedef enum logic [2:0] {R_IDLE, R_MUL1, R_MUL2, R_SCALE, R_SQRT} t_rstate;

    t_rstate                   r_state;
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]           r_acc, r_sq;
    logic [N_W-1:0]            r_n, r_r, r_bit;
    logic [4:0]                r_cnt;
    logic                      r_valid;

    logic signed [DELTA_W-1:0] w_op;
    logic signed [SQ_W-1:0]    w_prod;
    logic [N_W:0]              w_trial;

    always_comb begin
        w_op    = (r_state == R_MUL1) ? r_dx : r_dy;
        w_prod  = w_op * w_op;
        w_trial = {1'b0, r_r} + {1'b0, r_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= R_MUL1;
            r_valid <= 1'b0;
            r_dx    <= i_dx;
            r_dy    <= i_dy;
        end else begin
            unique case (r_state)
                R_IDLE: ;
                R_MUL1: begin
                    r_acc   <= w_prod;
                    r_state <= R_MUL2;
                end
                R_MUL2: begin
                    r_sq    <= r_acc + w_prod;
                    r_n     <= '0;
                    r_cnt   <= '0;
                    r_state <= R_SCALE;
                end
                R_SCALE: begin
                    r_n <= r_n + ({{(N_W-SQ_W){1'b0}}, r_sq} << scale_shift(r_cnt[2:0]));
                    if (r_cnt == 5'(SCALE_TERMS - 1)) begin
                        r_cnt   <= '0;
                        r_r     <= '0;
                        r_bit   <= N_W'(1) << (N_W - 2);
                        r_state <= R_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                R_SQRT: begin
                    if ({1'b0, r_n} >= w_trial) begin
                        r_n <= r_n - w_trial[N_W-1:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        r_state <= R_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    // mm = root / 16, saturated
    assign o_valid    = r_valid;
    assign o_range_mm = (|r_r[N_W-1:MM_W+4]) ? MM_SAT : r_r[MM_W+3:4];

    property p_valid_idle;
        @(posedge i_clk) disable iff (!i_rst_n) r_valid |-> (r_state == R_IDLE);
    endproperty
    a_valid_idle: assert property (p_valid_idle) else $error("range valid while running");

    property p_sqrt_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == R_SQRT) |-> (r_cnt < 5'(SQRT_STEPS));
    endproperty
    a_sqrt_bound: assert property (p_sqrt_bound) else $error("sqrt step overrun");

    property p_finish;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(r_valid) |-> $past(r_state == R_SQRT);
    endproperty
    a_finish: assert property (p_finish) else $error("range valid without a run");

endmodule

>>> design/hpps_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on hpps_pkg for widths.
`timescale 1ns / 1ps

module hpps_div import hpps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SPAN_W-1:0] i_den,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot
);

    logic [SPAN_W-1:0] r_rem, r_den;
    logic [NUM_W-1:0]  r_q;
    logic [4:0]        r_cnt;
    logic              r_busy, r_valid;
    logic [SPAN_W:0]   w_trial;

    assign w_trial = {r_rem, r_q[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_q     <= i_num;
            r_den   <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= SPAN_W'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[SPAN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(NUM_W - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_q;

    property p_rem_below_den;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_rem < r_den);
    endproperty
    a_rem_below_den: assert property (p_rem_below_den) else $error("remainder not below divisor");

    property p_valid_not_busy;
        @(posedge i_clk) disable iff (!i_rst_n) !(r_valid && r_busy);
    endproperty
    a_valid_not_busy: assert property (p_valid_not_busy) else $error("divider valid while busy");

    property p_finish;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_valid) |-> $past(r_busy);
    endproperty
    a_finish: assert property (p_finish) else $error("divider valid without a run");

endmodule

>>> design/hit_point_to_polar_scan_bins_core.sv
// Top level: config registers, command sequencer, bin RAM and output register.
// Depends on hpps_pkg, hpps_bin_mem, hpps_cordic, hpps_range, hpps_div.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready| tuser: cmd; tdata: hit_x, hit_y, read_bin
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready| tuser: bin_written; tdata: bin_number, range_mm
//  cfg       | in  | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
//  Hit word: square root (27 steps after 7 setup) then divider (28 steps).
//  Read word: through the registered RAM port, then S_RDWAIT. Start word: one RAM write
//  per cycle over all bins. cmd 3: straight to the output register.
//  After reset a clearing pass fills the RAM; no word is taken meanwhile.
//  One word is processed at a time; a new word is taken while the output register still
//  holds a result. Config writes are taken in every cycle.

module hit_point_to_polar_scan_bins_core import hpps_pkg::*; #(
    parameter int BIN_COUNT = BIN_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [55:0]          i_s_axis_tdata,   // hit_x[19:0], hit_y[39:20], read_bin[51:40]
    input  logic [1:0]           i_s_axis_tuser,   // cmd[1:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [39:0]          o_m_axis_tdata,   // bin_number[11:0], range_mm[33:12]
    output logic                 o_m_axis_tuser,   // bin_written
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data
);

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [BNUM_W-1:0] BIN_LAST = BNUM_W'(BIN_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CALC, S_DIVGO, S_DIV, S_RDWAIT, S_OUT
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    logic [MM_W-1:0]          r_fill;
    logic                     r_emit;

    logic [POS_W-1:0]         r_pose_x, r_pose_y;
    logic [ANG_W-1:0]         r_heading, r_first, r_last, r_maxrng;

    logic                     r_rd_ok;
    logic signed [PROD_W-1:0] r_num;
    logic signed [ANG_W:0]    r_span;
    logic                     r_res_written;
    logic [BNUM_W-1:0]        r_res_bin;
    logic [MM_W-1:0]          r_res_mm;

    logic                     r_out_valid, r_out_written;
    logic [BNUM_W-1:0]        r_out_bin;
    logic [MM_W-1:0]          r_out_mm;

    logic                     w_accept, w_hit_go, w_out_load, w_bin_ok;
    t_cmd                     w_cmd;
    logic [POS_W-1:0]         w_hit_x, w_hit_y;
    logic [BNUM_W-1:0]        w_read_bin;
    logic [DELTA_W-1:0]       w_dx, w_dy;
    logic                     w_cor_valid, w_rng_valid, w_div_valid;
    logic [ANG_W-1:0]         w_bearing, w_rel;
    logic signed [ANG_W:0]    w_diff;
    logic [MM_W-1:0]          w_mm, w_rdata;
    logic [NUM_W-1:0]         w_num_abs, w_quot;
    logic [PROD_W-1:0]        w_num_neg;
    t_mem_ctl                 w_mem_ctl;
    logic [AW-1:0]            w_mem_addr;
    logic [MM_W-1:0]          w_mem_wdata;

    assign w_cmd      = t_cmd'(i_s_axis_tuser);
    assign w_hit_x    = i_s_axis_tdata[19:0];
    assign w_hit_y    = i_s_axis_tdata[39:20];
    assign w_read_bin = i_s_axis_tdata[51:40];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_hit_go        = w_accept && (w_cmd == CMD_HIT);
    assign w_out_load      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    assign w_dx = {w_hit_x[POS_W-1], w_hit_x} - {r_pose_x[POS_W-1], r_pose_x};
    assign w_dy = {w_hit_y[POS_W-1], w_hit_y} - {r_pose_y[POS_W-1], r_pose_y};

    assign w_rel  = w_bearing - r_heading;
    assign w_diff = {w_rel[ANG_W-1], w_rel} - {r_first[ANG_W-1], r_first};

    assign w_num_neg = -r_num;
    assign w_num_abs = r_num[PROD_W-1] ? w_num_neg[NUM_W-1:0] : r_num[NUM_W-1:0];
    // toward-zero truncation: a negative numerator only lands in bin 0
    assign w_bin_ok  = (!r_num[PROD_W-1] || (w_quot == '0))
                       && (w_quot < NUM_W'(BIN_COUNT));

    hpps_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_hit_go),
        .i_dx      (w_dx),
        .i_dy      (w_dy),
        .o_valid   (w_cor_valid),
        .o_bearing (w_bearing)
    );

    hpps_range u_range (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_hit_go),
        .i_dx       (w_dx),
        .i_dy       (w_dy),
        .o_valid    (w_rng_valid),
        .o_range_mm (w_mm)
    );

    hpps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DIVGO) && (r_span > 0)),
        .i_num   (w_num_abs),
        .i_den   (r_span[SPAN_W-1:0]),
        .o_valid (w_div_valid),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_mem_ctl   = '0;
        w_mem_addr  = r_clr_addr;
        w_mem_wdata = r_fill;
        if (r_state == S_CLEAR) begin
            w_mem_ctl.wr_en = 1'b1;
        end else if ((r_state == S_DIV) && w_div_valid && w_bin_ok) begin
            w_mem_ctl.wr_en = 1'b1;
            w_mem_addr      = w_quot[AW-1:0];
            w_mem_wdata     = r_res_mm;
        end else if (w_accept && (w_cmd == CMD_READ)) begin
            w_mem_ctl.rd_en = 1'b1;
            w_mem_addr      = w_read_bin[AW-1:0];
        end
    end

    hpps_bin_mem #(
        .DEPTH (BIN_COUNT),
        .AW    (AW),
        .DW    (MM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_heading <= '0;
            r_first   <= 16'h8000;
            r_last    <= 16'h7FFF;
            r_maxrng  <= 16'd200;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POSE_X:  r_pose_x  <= i_cfg_data;
                CFG_POSE_Y:  r_pose_y  <= i_cfg_data;
                CFG_HEADING: r_heading <= i_cfg_data[ANG_W-1:0];
                CFG_FIRST:   r_first   <= i_cfg_data[ANG_W-1:0];
                CFG_LAST:    r_last    <= i_cfg_data[ANG_W-1:0];
                CFG_MAXRNG:  r_maxrng  <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_fill      <= RESET_FILL;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid   <= 1'b1;
                r_out_written <= r_res_written;
                r_out_bin     <= r_res_bin;
                r_out_mm      <= r_res_mm;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(BIN_COUNT - 1)) begin
                        r_state <= r_emit ? S_OUT : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_written <= 1'b0;
                        r_res_bin     <= '0;
                        r_res_mm      <= '0;
                        unique case (w_cmd)
                            CMD_START: begin
                                r_fill     <= MM_W'(r_maxrng) * MM_W'(MM_PER_PX);
                                r_clr_addr <= '0;
                                r_emit     <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            CMD_HIT: r_state <= S_CALC;
                            CMD_READ: begin
                                r_res_bin <= w_read_bin;
                                r_rd_ok   <= {1'b0, w_read_bin} < (BNUM_W+1)'(BIN_COUNT);
                                r_state   <= S_RDWAIT;
                            end
                            CMD_NONE: r_state <= S_OUT;
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_CALC: begin
                    if (w_cor_valid && w_rng_valid) begin
                        r_res_mm <= w_mm;
                        r_num    <= w_diff * $signed({1'b0, BIN_LAST});
                        r_span   <= {r_last[ANG_W-1], r_last} - {r_first[ANG_W-1], r_first};
                        r_state  <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    // empty or inverted span: no bin
                    r_state <= (r_span > 0) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (w_div_valid) begin
                        if (w_bin_ok) begin
                            r_res_written <= 1'b1;
                            r_res_bin     <= w_quot[BNUM_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_RDWAIT: begin
                    r_res_mm <= r_rd_ok ? w_rdata : '0;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_written;
    assign o_m_axis_tdata  = {6'd0, r_out_mm, r_out_bin};

    property p_no_write_idle;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_IDLE) |-> !w_mem_ctl.wr_en;
    endproperty
    a_no_write_idle: assert property (p_no_write_idle) else $error("RAM write while idle");

    property p_write_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_mem_ctl.wr_en |-> (w_mem_addr <= AW'(BIN_COUNT - 1));
    endproperty
    a_write_in_range: assert property (p_write_in_range) else $error("RAM write beyond bins");

    property p_out_from_seq;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_out_valid) |-> $past(r_state == S_OUT);
    endproperty
    a_out_from_seq: assert property (p_out_from_seq) else $error("result word without sequencer");

endmodule
